// ===== rtl/csbr_pkg.sv =====
`timescale 1ns / 1ps

package csbr_pkg;

    // Pool geometry
    localparam int FRAMES    = 16;
    localparam int FRAME_W   = $clog2(FRAMES);
    localparam int PAGE_BITS = 16;
    localparam int USE_W     = 3;

    // Usage cap after reset
    localparam logic [USE_W-1:0] CAP_RESET = USE_W'(5);

    // Operations carried in the input item
    typedef enum logic [1:0] {
        CMD_FETCH = 2'd0,
        CMD_PIN   = 2'd1,
        CMD_UNPIN = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // Result codes
    typedef enum logic [2:0] {
        RES_HIT        = 3'd0,
        RES_MISS_EMPTY = 3'd1,
        RES_MISS_EVICT = 3'd2,
        RES_ALL_PINNED = 3'd3,
        RES_FLAG       = 3'd4,
        RES_ABSENT     = 3'd5
    } res_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;     // latch the incoming transfer
        logic lookup;      // latch match result
        logic sweep_step;  // visit the frame under the hand
        logic commit;      // update frame state and load result register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        cmd_t op;
        logic hit;
        logic all_pinned;
        logic victim_found;
    } dp_stat_t;

endpackage

// ===== rtl/csbr_ctrl.sv =====
`timescale 1ns / 1ps

module csbr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  csbr_pkg::dp_stat_t  stat,
    output csbr_pkg::dp_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOKUP = 4'b0010,
        S_SWEEP  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    // Result slot can take a new result when empty or being drained
    assign slot_free = !out_valid_reg || m_tready;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                cmd.lookup = 1'b1;
                if (stat.op == csbr_pkg::CMD_FETCH && !stat.hit && !stat.all_pinned) begin
                    state_next = S_SWEEP;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (stat.victim_found) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (slot_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

// ===== rtl/csbr_datapath.sv =====
`timescale 1ns / 1ps

module csbr_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [csbr_pkg::USE_W-1:0]         cfg_wr_data,
    input  logic [1:0]                         in_cmd,
    input  logic [csbr_pkg::PAGE_BITS-1:0]     in_page,
    input  csbr_pkg::dp_cmd_t                  cmd,
    output csbr_pkg::dp_stat_t                 stat,
    output logic [2:0]                         out_status,
    output logic [csbr_pkg::FRAME_W-1:0]       out_frame,
    output logic [csbr_pkg::PAGE_BITS-1:0]     out_evicted,
    output logic [csbr_pkg::USE_W-1:0]         out_usage
);

    localparam int FRAMES = csbr_pkg::FRAMES;
    localparam int FW     = csbr_pkg::FRAME_W;
    localparam int PW     = csbr_pkg::PAGE_BITS;
    localparam int UW     = csbr_pkg::USE_W;

    // Frame state
    logic [PW-1:0]     page_reg   [FRAMES];
    logic [FRAMES-1:0] valid_reg, valid_next;
    logic [FRAMES-1:0] pinned_reg, pinned_next;
    logic [UW-1:0]     usage_reg  [FRAMES];
    logic [UW-1:0]     usage_next [FRAMES];
    logic [FW-1:0]     hand_reg, hand_next;
    logic [UW-1:0]     cap_reg, cap_next;

    // Current transfer and lookup results
    csbr_pkg::cmd_t    op_reg;
    logic [PW-1:0]     pg_reg;
    logic              hit_reg;
    logic [FW-1:0]     idx_reg;
    logic              all_pinned_reg;
    logic [FW-1:0]     victim_reg, victim_next;

    // Result register
    logic [2:0]        status_reg;
    logic [FW-1:0]     frame_out_reg;
    logic [PW-1:0]     evict_out_reg;
    logic [UW-1:0]     usage_out_reg;

    logic [2:0]        res_status;
    logic [FW-1:0]     res_frame;
    logic [PW-1:0]     res_evict;
    logic [UW-1:0]     res_usage;

    logic              match_hit;
    logic [FW-1:0]     match_idx;
    logic              page_we;
    logic [UW-1:0]     hit_use;
    logic [UW-1:0]     hand_use;

    // Parallel match, lowest frame wins
    always_comb begin
        match_hit = 1'b0;
        match_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (valid_reg[i] && page_reg[i] == pg_reg) begin
                match_hit = 1'b1;
                match_idx = FW'(i);
            end
        end
    end

    assign hand_use = usage_reg[hand_reg];

    assign stat.op           = op_reg;
    assign stat.hit          = match_hit;
    assign stat.all_pinned   = &pinned_reg;
    assign stat.victim_found = !pinned_reg[hand_reg] && hand_use == '0;

    // Saturating increment on a hit
    always_comb begin
        hit_use = usage_reg[idx_reg];
        if (hit_use < cap_reg) begin
            hit_use = hit_use + UW'(1);
        end
    end

    // Config register, zero is taken as one
    always_comb begin
        cap_next = cap_reg;
        if (cfg_wr_en) begin
            cap_next = (cfg_wr_data == '0) ? UW'(1) : cfg_wr_data;
        end
    end

    // Sweep step and commit updates
    always_comb begin
        valid_next  = valid_reg;
        pinned_next = pinned_reg;
        usage_next  = usage_reg;
        hand_next   = hand_reg;
        victim_next = victim_reg;
        page_we     = 1'b0;
        res_status  = csbr_pkg::RES_ABSENT;
        res_frame   = '0;
        res_evict   = '0;
        res_usage   = '0;

        if (cmd.sweep_step) begin
            hand_next = (hand_reg == FW'(FRAMES - 1)) ? '0 : hand_reg + FW'(1);
            if (!pinned_reg[hand_reg]) begin
                if (hand_use == '0) begin
                    victim_next = hand_reg;
                end else begin
                    usage_next[hand_reg] = hand_use - UW'(1);
                end
            end
        end

        if (cmd.commit) begin
            unique case (op_reg)
                csbr_pkg::CMD_PIN, csbr_pkg::CMD_UNPIN: begin
                    if (hit_reg) begin
                        pinned_next[idx_reg] = (op_reg == csbr_pkg::CMD_PIN);
                        res_status = csbr_pkg::RES_FLAG;
                        res_frame  = idx_reg;
                        res_usage  = usage_reg[idx_reg];
                    end
                end
                csbr_pkg::CMD_FETCH: begin
                    if (hit_reg) begin
                        usage_next[idx_reg] = hit_use;
                        res_status = csbr_pkg::RES_HIT;
                        res_frame  = idx_reg;
                        res_usage  = hit_use;
                    end else if (all_pinned_reg) begin
                        res_status = csbr_pkg::RES_ALL_PINNED;
                    end else begin
                        page_we                 = 1'b1;
                        valid_next[victim_reg]  = 1'b1;
                        pinned_next[victim_reg] = 1'b0;
                        usage_next[victim_reg]  = UW'(1);
                        res_frame  = victim_reg;
                        res_usage  = UW'(1);
                        if (valid_reg[victim_reg]) begin
                            res_status = csbr_pkg::RES_MISS_EVICT;
                            res_evict  = page_reg[victim_reg];
                        end else begin
                            res_status = csbr_pkg::RES_MISS_EMPTY;
                        end
                    end
                end
                csbr_pkg::CMD_NOP: begin
                    res_status = csbr_pkg::RES_ABSENT;
                end
                default: begin
                    res_status = csbr_pkg::RES_ABSENT;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            pinned_reg <= '0;
            hand_reg   <= '0;
            cap_reg    <= csbr_pkg::CAP_RESET;
            for (int i = 0; i < FRAMES; i++) begin
                usage_reg[i] <= '0;
            end
        end else begin
            valid_reg  <= valid_next;
            pinned_reg <= pinned_next;
            hand_reg   <= hand_next;
            cap_reg    <= cap_next;
            usage_reg  <= usage_next;
        end
    end

    // Page tags, written only on a load
    always_ff @(posedge aclk) begin
        if (page_we) begin
            page_reg[victim_reg] <= pg_reg;
        end
    end

    // Transfer capture, lookup latch, victim and result payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg <= csbr_pkg::cmd_t'(in_cmd);
            pg_reg <= in_page;
        end
        if (cmd.lookup) begin
            hit_reg        <= match_hit;
            idx_reg        <= match_idx;
            all_pinned_reg <= &pinned_reg;
        end
        victim_reg <= victim_next;
        if (cmd.commit) begin
            status_reg    <= res_status;
            frame_out_reg <= res_frame;
            evict_out_reg <= res_evict;
            usage_out_reg <= res_usage;
        end
    end

    assign out_status  = status_reg;
    assign out_frame   = frame_out_reg;
    assign out_evicted = evict_out_reg;
    assign out_usage   = usage_out_reg;

endmodule

// ===== rtl/clock_sweep_buffer_replacement_top.sv =====
`timescale 1ns / 1ps
// An input transfer is captured, looked up and committed to the result register, which raises
// result valid; a fetch miss that finds an unpinned frame first sweeps the clock hand to a victim.
// The sweep visits one frame per step. One item at a time: input reopens after the commit. A waiting
// result does not stop the next transfer, but holds that item's commit until the result is taken.
// Reset (aresetn low, synchronous): all frames empty, unpinned, usage zero,
// hand at frame zero, usage_cap 5; no clearing pass is needed.
module clock_sweep_buffer_replacement_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,   // usage_cap
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // [15:0] page_number
    input  logic [1:0]  s_tuser,       // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,       // [3:0] frame_index, [19:4] evicted_page,
                                       // [22:20] usage_after, [23] zero
    output logic [2:0]  m_tuser        // [2:0] status
);

    csbr_pkg::dp_cmd_t  cmd;
    csbr_pkg::dp_stat_t stat;

    logic [csbr_pkg::FRAME_W-1:0]   out_frame;
    logic [csbr_pkg::PAGE_BITS-1:0] out_evicted;
    logic [csbr_pkg::USE_W-1:0]     out_usage;

    csbr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    csbr_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_cmd      (s_tuser),
        .in_page     (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .out_status  (m_tuser),
        .out_frame   (out_frame),
        .out_evicted (out_evicted),
        .out_usage   (out_usage)
    );

    // Pack result payload
    assign m_tdata = {1'b0, out_usage, out_evicted, out_frame};

`ifndef SYNTH
    // One item at a time: input closes right after a transfer
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // A commit always presents a result on the next cycle
    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid)
        else $error("committed result not presented");

    // All-pinned and absent results carry no frame, page or usage
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == csbr_pkg::RES_ALL_PINNED || m_tuser == csbr_pkg::RES_ABSENT)
        |-> m_tdata == '0)
        else $error("failed result carries nonzero fields");

    // Only eviction results name an evicted page
    a_evict_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != csbr_pkg::RES_MISS_EVICT |-> m_tdata[19:4] == '0)
        else $error("evicted page reported without eviction");
`endif

endmodule

// ===== tb/sv/clock_sweep_buffer_replacement_top_tb.sv =====
`timescale 1ns / 1ps

module clock_sweep_buffer_replacement_top_tb;
    import csbr_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 250;
    localparam int PHASE_ITEMS = 140;
    localparam int SET_SIZE    = 24;
    localparam int CAP_STEPS   = 7;

    // One command for the frame pool
    typedef struct {
        cmd_t                 op;
        logic [PAGE_BITS-1:0] page;
    } pool_cmd_t;

    // One predicted answer
    typedef struct {
        res_t                 status;
        logic [FRAME_W-1:0]   frame;
        logic [PAGE_BITS-1:0] evicted;
        logic [USE_W-1:0]     usage;
    } pool_outcome_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [2:0]  cfg_wr_data = 3'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = 16'd0;   // [15:0] page_number
    logic [1:0]  s_tuser     = 2'd0;    // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [23:0] m_tdata;               // [3:0] frame_index, [19:4] evicted_page,
                                        // [22:20] usage_after, [23] zero
    logic [2:0]  m_tuser;               // [2:0] status

    clock_sweep_buffer_replacement_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // Shadow of the frame pool
    logic [PAGE_BITS-1:0] mdl_page   [FRAMES];
    logic                 mdl_valid  [FRAMES];
    logic [USE_W-1:0]     mdl_usage  [FRAMES];
    logic                 mdl_pinned [FRAMES];
    logic [FRAME_W-1:0]   mdl_hand;
    logic [USE_W-1:0]     mdl_cap;

    pool_cmd_t     pending_cmds[$];
    pool_outcome_t expected_outcomes[$];

    int items_queued  = 0;
    int items_taken   = 0;
    int results_seen  = 0;
    int fail_count    = 0;
    int stall_cycles  = 0;
    int outcome_tally [6];

    // Idle control for both sides
    int   tx_idle_odds = 0;
    int   rx_idle_odds = 0;
    int   tx_gap_left  = 0;
    int   rx_gap_left  = 0;
    int   rx_hold_left = 0;
    logic rx_hold_req  = 1'b0;
    logic tx_done      = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Frame pool behavior for one accepted command
    task automatic predict_frame_outcome(input cmd_t op, input logic [PAGE_BITS-1:0] page);
        pool_outcome_t      res;
        int                 hit_idx;
        int                 victim;
        logic               any_free;
        logic [FRAME_W-1:0] h;
        res     = '{RES_ABSENT, '0, '0, '0};
        hit_idx = -1;
        if (op != CMD_NOP) begin
            for (int i = FRAMES - 1; i >= 0; i--) begin
                if (mdl_valid[i] && mdl_page[i] == page)
                    hit_idx = i;
            end
            if (op == CMD_PIN || op == CMD_UNPIN) begin
                if (hit_idx >= 0) begin
                    mdl_pinned[hit_idx] = (op == CMD_PIN);
                    res = '{RES_FLAG, FRAME_W'(hit_idx), '0, mdl_usage[hit_idx]};
                end
            end else if (hit_idx >= 0) begin
                if (mdl_usage[hit_idx] < mdl_cap)
                    mdl_usage[hit_idx] = mdl_usage[hit_idx] + 1'b1;
                res = '{RES_HIT, FRAME_W'(hit_idx), '0, mdl_usage[hit_idx]};
            end else begin
                any_free = 1'b0;
                for (int i = 0; i < FRAMES; i++) begin
                    if (!mdl_pinned[i])
                        any_free = 1'b1;
                end
                if (!any_free) begin
                    res = '{RES_ALL_PINNED, '0, '0, '0};
                end else begin
                    // hand sweep: take a cold unpinned frame, cool the others
                    victim = -1;
                    while (victim < 0) begin
                        h        = mdl_hand;
                        mdl_hand = FRAME_W'((int'(h) + 1) % FRAMES);
                        if (!mdl_pinned[h]) begin
                            if (mdl_usage[h] == '0)
                                victim = int'(h);
                            else
                                mdl_usage[h] = mdl_usage[h] - 1'b1;
                        end
                    end
                    if (mdl_valid[victim])
                        res = '{RES_MISS_EVICT, FRAME_W'(victim), mdl_page[victim], USE_W'(1)};
                    else
                        res = '{RES_MISS_EMPTY, FRAME_W'(victim), '0, USE_W'(1)};
                    mdl_page[victim]   = page;
                    mdl_valid[victim]  = 1'b1;
                    mdl_usage[victim]  = USE_W'(1);
                    mdl_pinned[victim] = 1'b0;
                end
            end
        end
        expected_outcomes.push_back(res);
    endtask

    task automatic queue_item(input cmd_t op, input logic [PAGE_BITS-1:0] page);
        pending_cmds.push_back('{op, page});
        items_queued++;
    endtask

    // Block is idle once every command has been taken and answered
    task automatic wait_for_drain();
        do
            @(negedge aclk);
        while (items_taken != items_queued || expected_outcomes.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_usage_cap(input logic [USE_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        mdl_cap = (value == '0) ? USE_W'(1) : value;
    endtask

    // Fill and pin every frame, hit the all-pinned miss, then release
    task automatic pin_every_frame(input logic [11:0] tag);
        for (int i = 0; i < FRAMES; i++) begin
            queue_item(CMD_FETCH, {tag, 4'(i)});
            queue_item(CMD_PIN, {tag, 4'(i)});
        end
        queue_item(CMD_FETCH, {~tag, 4'h0});
        queue_item(CMD_PIN, {~tag, 4'h0});
        queue_item(CMD_UNPIN, {tag, 4'h5});
        queue_item(CMD_FETCH, {~tag, 4'h0});
        for (int i = 0; i < FRAMES; i++)
            queue_item(CMD_UNPIN, {tag, 4'(i)});
    endtask

    // Sender: present queued commands, with random gaps
    always @(negedge aclk) begin : feed_cmds
        pool_cmd_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !tx_done)) begin
            tx_done = 1'b0;
            if (tx_gap_left > 0) begin
                tx_gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_cmds.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (tx_idle_odds != 0 && $urandom_range(1, tx_idle_odds) == 1) begin
                tx_gap_left = $urandom_range(0, 2);
                s_tvalid <= 1'b0;
            end else begin
                nxt = pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.op;
                s_tdata  <= nxt.page;
            end
        end
    end

    // Receiver: ready with random gaps and one long hold-off
    always @(negedge aclk) begin : drain_results
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_req) begin
            rx_hold_req  = 1'b0;
            rx_hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else if (rx_gap_left > 0) begin
            rx_gap_left--;
            m_tready <= 1'b0;
        end else if (rx_idle_odds != 0 && $urandom_range(1, rx_idle_odds) == 1) begin
            rx_gap_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Input transfers feed the predictor; result transfers are checked
    always @(posedge aclk) begin : watch_transfers
        pool_outcome_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_frame_outcome(cmd_t'(s_tuser), s_tdata);
                items_taken++;
                tx_done = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (m_tuser < 3'd6)
                    outcome_tally[m_tuser]++;
                if (expected_outcomes.size() == 0) begin
                    $error("result with nothing expected: status %0d tdata %h", m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (m_tuser !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[3:0] !== want.frame) begin
                        $error("frame_index expected %0d actual %0d", want.frame, m_tdata[3:0]);
                        fail_count++;
                    end
                    if (m_tdata[19:4] !== want.evicted) begin
                        $error("evicted_page expected %h actual %h", want.evicted,
                               m_tdata[19:4]);
                        fail_count++;
                    end
                    if (m_tdata[22:20] !== want.usage) begin
                        $error("usage_after expected %0d actual %0d", want.usage,
                               m_tdata[22:20]);
                        fail_count++;
                    end
                    if (m_tdata[23] !== 1'b0) begin
                        $error("tdata pad expected 0 actual %b", m_tdata[23]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: %0d cycles without a transfer", stall_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin : run_regression
        int                   cap_steps [CAP_STEPS];
        logic [PAGE_BITS-1:0] working_set [SET_SIZE];
        logic [PAGE_BITS-1:0] pg;
        int                   dice;
        cap_steps = '{7, 1, 0, 4, 2, 6, 3};
        cap_steps[6] = $urandom_range(1, 7);
        for (int i = 0; i < 6; i++)
            outcome_tally[i] = 0;
        for (int i = 0; i < FRAMES; i++) begin
            mdl_page[i]   = '0;
            mdl_valid[i]  = 1'b0;
            mdl_usage[i]  = '0;
            mdl_pinned[i] = 1'b0;
        end
        for (int i = 0; i < SET_SIZE; i++)
            working_set[i] = '0;
        mdl_hand = '0;
        mdl_cap  = CAP_RESET;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty fills, saturation at the reset cap, flags, absent pages, nop
        queue_item(CMD_FETCH, 16'h0000);
        queue_item(CMD_FETCH, 16'hFFFF);
        repeat (5) queue_item(CMD_FETCH, 16'h0000);
        queue_item(CMD_PIN, 16'hFFFF);
        queue_item(CMD_FETCH, 16'hFFFF);
        queue_item(CMD_UNPIN, 16'hFFFF);
        queue_item(CMD_PIN, 16'h1234);
        queue_item(CMD_UNPIN, 16'h1234);
        queue_item(CMD_NOP, 16'hFFFF);
        queue_item(CMD_NOP, 16'h0000);
        queue_item(CMD_FETCH, 16'h5A5A);
        queue_item(CMD_FETCH, 16'hA5A5);
        wait_for_drain();

        // Random phases, one cap setting each
        for (int phase = 0; phase < CAP_STEPS; phase++) begin
            write_usage_cap(USE_W'(cap_steps[phase]));
            @(posedge aclk);
            if (phase == CAP_STEPS - 1) begin
                tx_idle_odds = 0;
                rx_idle_odds = 0;
            end else if (phase % 3 == 0) begin
                tx_idle_odds = 4;
                rx_idle_odds = 4;
            end else if (phase % 3 == 1) begin
                tx_idle_odds = 0;
                rx_idle_odds = 3;
            end else begin
                tx_idle_odds = 3;
                rx_idle_odds = 0;
            end

            // release old pins, then drive the pool fully pinned
            if (phase == 2 || phase == 5) begin
                for (int k = 0; k < SET_SIZE; k++)
                    queue_item(CMD_UNPIN, working_set[k]);
                pin_every_frame(12'($urandom));
            end

            for (int k = 0; k < SET_SIZE; k++)
                working_set[k] = 16'($urandom);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                dice = $urandom_range(0, 99);
                pg   = working_set[$urandom_range(0, SET_SIZE - 1)];
                if (dice < 70)
                    queue_item(CMD_FETCH, pg);
                else if (dice < 80)
                    queue_item(CMD_PIN, pg);
                else if (dice < 90)
                    queue_item(CMD_UNPIN, pg);
                else if (dice < 95)
                    queue_item(cmd_t'($urandom_range(0, 3)), 16'($urandom));
                else
                    queue_item(CMD_NOP, pg);
            end

            // long receiver hold-off while the sender keeps offering
            if (phase == 1) begin
                while (items_queued - items_taken > PHASE_ITEMS / 2)
                    @(posedge aclk);
                rx_hold_req = 1'b1;
            end
            wait_for_drain();
        end

        repeat (20) @(negedge aclk);
        $display("run: %0d commands, %0d answers over %0d usage caps incl. 0 and 7",
                 items_taken, results_seen, CAP_STEPS + 1);
        $display("answers: hit %0d, fill %0d, evict %0d, all pinned %0d, flag %0d, absent %0d",
                 outcome_tally[0], outcome_tally[1], outcome_tally[2],
                 outcome_tally[3], outcome_tally[4], outcome_tally[5]);
        if (fail_count == 0 && expected_outcomes.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
